### hdl/scoreboard_digit_slot_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - assertion macros
// Shared concurrent assertion macros. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SCOREBOARD_DIGIT_SLOT_DECODER_CORE_ASSERT_SVH
`define SCOREBOARD_DIGIT_SLOT_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge of clk, ignored while rst is high.
`define SDSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen on a rising edge of clk.
`define SDSD_ASSERT_NEVER(lbl, cond, msg) \
  `SDSD_ASSERT(lbl, !(cond), msg)

`else

`define SDSD_ASSERT(lbl, prop, msg)
`define SDSD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### hdl/sdsd_pkg.sv
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - package
// Types, constants and small digit helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
package sdsd_pkg;

  // Display layout and glyph codes.
  localparam int CHANNEL_COUNT = 13;
  localparam int CH_W          = 4;
  localparam int GLYPH_W       = 4;
  localparam logic [CH_W-1:0]    LAST_CHANNEL = CH_W'(CHANNEL_COUNT - 1);
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 4'd10;
  localparam logic [GLYPH_W-1:0] GLYPH_OT     = 4'd11;

  // Field widths.
  localparam int TPS_W   = 16;
  localparam int GAME_W  = 24;
  localparam int SHOT_W  = 16;
  localparam int SCORE_W = 11;
  localparam int QTR_W   = 5;

  // Arithmetic constants.
  localparam logic [TPS_W-1:0]  DEFAULT_TPS   = 16'd60;
  localparam logic [9:0]        SCORE_MAX     = 10'd999;
  localparam logic [6:0]        TWO_DIGIT_MAX = 7'd99;
  localparam logic [GAME_W-1:0] MIN_SAT_SECS  = 24'd6000;
  localparam int                RECIP_60      = 17477;

  // Quotient bits resolved per divider stage.
  localparam int DIV_STEPS_PER_STAGE = 2;

  // Snapshot fields that ride alongside the division.
  typedef struct packed {
    logic                      ok;
    logic signed [SCORE_W-1:0] home;
    logic signed [SCORE_W-1:0] away;
    logic                      game_valid;
    logic                      shot_valid;
    logic signed [QTR_W-1:0]   quarter;
  } snap_t;

  typedef logic [CHANNEL_COUNT-1:0][GLYPH_W-1:0] glyph_vec_t;

  // Tens digit of a value below 100 (multiply by reciprocal of ten).
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  // Ones digit of a value below 100, given its tens digit.
  function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] x;
    x = v - 7'(t) * 7'd10;
    return x[3:0];
  endfunction

  // Hundreds digit of a value up to 999.
  function automatic logic [3:0] hundreds_of(input logic [9:0] s);
    logic [15:0] p;
    p = 16'(s) * 16'd41;
    return p[15:12];
  endfunction

  // Non-negative score limited to 999; negative scores are blanked elsewhere.
  function automatic logic [9:0] clamp_score(input logic signed [SCORE_W-1:0] sc);
    logic [9:0] s;
    if (sc[SCORE_W-1]) begin
      s = '0;
    end else if (sc[9:0] > SCORE_MAX) begin
      s = SCORE_MAX;
    end else begin
      s = sc[9:0];
    end
    return s;
  endfunction

endpackage

### hdl/sdsd_div_pipe.sv
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - divider pipeline
// Two restoring divider lanes (game clock and shot clock) by ticks per
// second, a fixed number of quotient bits per register stage.
// ----------------------------------------------------------------------------
module sdsd_div_pipe #(
  parameter int STEPS_PER_STAGE = sdsd_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [sdsd_pkg::GAME_W-1:0]     in_game,
  input  logic [sdsd_pkg::SHOT_W:0]       in_shot,
  input  sdsd_pkg::snap_t                 in_snap,
  input  logic [sdsd_pkg::TPS_W-1:0]      tps,
  output logic                            out_valid,
  output logic [sdsd_pkg::GAME_W-1:0]     out_total,
  output logic [sdsd_pkg::GAME_W-1:0]     out_shot,
  output sdsd_pkg::snap_t                 out_snap
);

  localparam int TPS_W  = sdsd_pkg::TPS_W;
  localparam int STAGES = (sdsd_pkg::GAME_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int NUM_W  = STAGES * STEPS_PER_STAGE;

  // Partial remainder and shifting dividend/quotient per stage.
  logic [STAGES-1:0]  valid;
  logic [TPS_W-1:0]   grem [STAGES];
  logic [NUM_W-1:0]   gnum [STAGES];
  logic [TPS_W-1:0]   srem [STAGES];
  logic [NUM_W-1:0]   snum [STAGES];
  sdsd_pkg::snap_t    snap [STAGES];

  // A few restoring steps: shift in the next dividend bit, trial subtract.
  function automatic logic [TPS_W+NUM_W-1:0] div_steps(
    input logic [TPS_W-1:0] rem_in,
    input logic [NUM_W-1:0] num_in,
    input logic [TPS_W-1:0] d
  );
    logic [TPS_W-1:0] r;
    logic [NUM_W-1:0] n;
    logic [TPS_W:0]   t;
    r = rem_in;
    n = num_in;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      t = {r, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        n[0] = 1'b1;
      end
      r = t[TPS_W-1:0];
    end
    return {r, n};
  endfunction

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
    logic [TPS_W-1:0] grem_in, srem_in, grem_n, srem_n;
    logic [NUM_W-1:0] gnum_in, snum_in, gnum_n, snum_n;
    logic             valid_in;
    sdsd_pkg::snap_t  snap_in;

    // Stage inputs: the first stage starts from a zero remainder.
    if (gi == 0) begin : g_first
      assign valid_in = in_valid;
      assign grem_in  = '0;
      assign gnum_in  = NUM_W'(in_game);
      assign srem_in  = '0;
      assign snum_in  = NUM_W'(in_shot);
      assign snap_in  = in_snap;
    end else begin : g_next
      assign valid_in = valid[gi-1];
      assign grem_in  = grem[gi-1];
      assign gnum_in  = gnum[gi-1];
      assign srem_in  = srem[gi-1];
      assign snum_in  = snum[gi-1];
      assign snap_in  = snap[gi-1];
    end

    // Both lanes share the divisor and advance together.
    always_comb begin
      {grem_n, gnum_n} = div_steps(grem_in, gnum_in, tps);
      {srem_n, snum_n} = div_steps(srem_in, snum_in, tps);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[gi] <= 1'b0;
      end else if (en) begin
        valid[gi] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        grem[gi] <= grem_n;
        gnum[gi] <= gnum_n;
        srem[gi] <= srem_n;
        snum[gi] <= snum_n;
        snap[gi] <= snap_in;
      end
    end
  end

  // After the last stage the shifting words hold the quotients.
  assign out_valid = valid[STAGES-1];
  assign out_total = gnum[STAGES-1][sdsd_pkg::GAME_W-1:0];
  assign out_shot  = snum[STAGES-1][sdsd_pkg::GAME_W-1:0];
  assign out_snap  = snap[STAGES-1];

endmodule

### hdl/sdsd_glyph.sv
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - glyph stages
// Three register stages that turn scores, clock quotients and period into
// the thirteen glyph slots, with all blanking rules applied.
// ----------------------------------------------------------------------------
module sdsd_glyph (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [sdsd_pkg::GAME_W-1:0]  in_total,
  input  logic [sdsd_pkg::GAME_W-1:0]  in_shot,
  input  sdsd_pkg::snap_t              in_snap,
  output logic                         out_valid,
  output sdsd_pkg::glyph_vec_t         out_glyphs
);

  // First stage registers.
  logic            v1;
  sdsd_pkg::snap_t snap1;
  logic [9:0]      home_s1, away_s1;
  logic [3:0]      home_h1, away_h1;
  logic [6:0]      nib_sum1;
  logic [1:0]      r4_1;
  logic [6:0]      mins1, shot1;

  // Second stage registers.
  logic            v2;
  sdsd_pkg::snap_t snap2;
  logic [3:0]      home_h2, away_h2;
  logic [6:0]      home_r2, away_r2;
  logic [5:0]      secs2;
  logic [6:0]      mins2, shot2;

  // Stage one combinational values.
  logic [9:0]  home_s, away_s;
  logic [6:0]  nib_sum, mins_c, shot_c;
  logic [27:0] mins_p;

  // Stage two combinational values.
  logic [4:0]  fold;
  logic [3:0]  r15;
  logic [1:0]  k;

  // Stage three combinational values.
  sdsd_pkg::glyph_vec_t g;
  logic [3:0] home_t, away_t, mins_t, secs_t, shot_t;

  // Stage one: clamp scores, take hundreds, fold seconds modulo 15 and
  // split out minutes, saturate the shot clock.
  always_comb begin
    home_s  = sdsd_pkg::clamp_score(in_snap.home);
    away_s  = sdsd_pkg::clamp_score(in_snap.away);
    nib_sum = '0;
    for (int i = 0; i < sdsd_pkg::GAME_W / 4; i++) begin
      nib_sum = nib_sum + 7'(in_total[4*i +: 4]);
    end
    mins_p = 28'(in_total[12:0]) * 28'(sdsd_pkg::RECIP_60);
    if (in_total >= sdsd_pkg::MIN_SAT_SECS) begin
      mins_c = sdsd_pkg::TWO_DIGIT_MAX;
    end else begin
      mins_c = mins_p[26:20];
    end
    if (in_shot > sdsd_pkg::GAME_W'(sdsd_pkg::TWO_DIGIT_MAX)) begin
      shot_c = sdsd_pkg::TWO_DIGIT_MAX;
    end else begin
      shot_c = in_shot[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap1    <= in_snap;
      home_s1  <= home_s;
      away_s1  <= away_s;
      home_h1  <= sdsd_pkg::hundreds_of(home_s);
      away_h1  <= sdsd_pkg::hundreds_of(away_s);
      nib_sum1 <= nib_sum;
      r4_1     <= in_total[1:0];
      mins1    <= mins_c;
      shot1    <= shot_c;
    end
  end

  // Stage two: score remainders below 100, seconds from residues mod 4 and 15.
  always_comb begin
    fold = 5'(nib_sum1[6:4]) + 5'(nib_sum1[3:0]);
    if (fold >= 5'd15) begin
      r15 = 4'(fold - 5'd15);
    end else begin
      r15 = fold[3:0];
    end
    k = r15[1:0] - r4_1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap2   <= snap1;
      home_h2 <= home_h1;
      away_h2 <= away_h1;
      home_r2 <= 7'(home_s1 - 10'(home_h1) * 10'd100);
      away_r2 <= 7'(away_s1 - 10'(away_h1) * 10'd100);
      secs2   <= 6'(r15) + 6'(k) * 6'd15;
      mins2   <= mins1;
      shot2   <= shot1;
    end
  end

  // Stage three: tens and ones digits, then blanking per channel.
  always_comb begin
    home_t = sdsd_pkg::tens_of(home_r2);
    away_t = sdsd_pkg::tens_of(away_r2);
    mins_t = sdsd_pkg::tens_of(mins2);
    secs_t = sdsd_pkg::tens_of(7'(secs2));
    shot_t = sdsd_pkg::tens_of(shot2);
    for (int c = 0; c < sdsd_pkg::CHANNEL_COUNT; c++) begin
      g[c] = sdsd_pkg::GLYPH_BLANK;
    end
    if (snap2.ok) begin
      if (!snap2.home[sdsd_pkg::SCORE_W-1]) begin
        if (home_h2 != 4'd0) begin
          g[0] = home_h2;
        end
        if (home_h2 != 4'd0 || home_r2 >= 7'd10) begin
          g[1] = home_t;
        end
        g[2] = sdsd_pkg::ones_of(home_r2, home_t);
      end
      if (!snap2.away[sdsd_pkg::SCORE_W-1]) begin
        if (away_h2 != 4'd0) begin
          g[3] = away_h2;
        end
        if (away_h2 != 4'd0 || away_r2 >= 7'd10) begin
          g[4] = away_t;
        end
        g[5] = sdsd_pkg::ones_of(away_r2, away_t);
      end
      if (snap2.game_valid) begin
        if (mins_t != 4'd0) begin
          g[6] = mins_t;
        end
        g[7] = sdsd_pkg::ones_of(mins2, mins_t);
        g[8] = secs_t;
        g[9] = sdsd_pkg::ones_of(7'(secs2), secs_t);
      end
      if (snap2.shot_valid) begin
        if (shot_t != 4'd0) begin
          g[10] = shot_t;
        end
        g[11] = sdsd_pkg::ones_of(shot2, shot_t);
      end
      // Period: regular periods one to four, overtime beyond.
      if (snap2.quarter[sdsd_pkg::QTR_W-1]) begin
        g[12] = sdsd_pkg::GLYPH_BLANK;
      end else if (snap2.quarter[sdsd_pkg::QTR_W-2:2] == '0) begin
        g[12] = 4'(snap2.quarter[1:0]) + 4'd1;
      end else begin
        g[12] = sdsd_pkg::GLYPH_OT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_glyphs <= g;
    end
  end

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

### hdl/sdsd_serial.sv
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - result serialiser
// Holds one snapshot's thirteen glyphs and emits one result beat per cycle.
// ----------------------------------------------------------------------------
`include "scoreboard_digit_slot_decoder_core_assert.svh"

module sdsd_serial (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  sdsd_pkg::glyph_vec_t          in_glyphs,
  output logic                          ready,
  output logic                          strobe,
  output logic [sdsd_pkg::CH_W-1:0]     channel,
  output logic [sdsd_pkg::GLYPH_W-1:0]  glyph_slot,
  output logic                          last
);

  logic                        active;
  logic [sdsd_pkg::CH_W-1:0]   cnt;
  sdsd_pkg::glyph_vec_t        glyphs;
  logic                        load;

  // A new snapshot may load during the final beat of the current one.
  assign ready = !active || cnt == sdsd_pkg::LAST_CHANNEL;
  assign load  = in_valid && ready;

  // Beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active && cnt == sdsd_pkg::LAST_CHANNEL) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (active) begin
      cnt    <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      glyphs <= in_glyphs;
    end
  end

  assign strobe     = active;
  assign channel    = cnt;
  assign glyph_slot = glyphs[cnt];
  assign last       = cnt == sdsd_pkg::LAST_CHANNEL;

  // A snapshot's beats follow each other without gaps.
  `SDSD_ASSERT(a_beats_contiguous, (strobe && !last) |=> (strobe && channel == $past(channel) + 4'd1), "beat sequence broken")
  // Every run of beats begins at channel zero.
  `SDSD_ASSERT(a_run_starts_at_zero, !strobe |=> (!strobe || channel == '0), "run did not start at channel zero")
  // After the final beat either a new run starts or the output falls quiet.
  `SDSD_ASSERT(a_after_last, (strobe && last) |=> (!strobe || channel == '0), "beat after last not a fresh run")

endmodule

### hdl/scoreboard_digit_slot_decoder_core.sv
// ----------------------------------------------------------------------------
// Scoreboard digit slot decoder - top level
// Turns one scoreboard snapshot into thirteen channel/glyph results.
// ----------------------------------------------------------------------------
// Usage:
//   A snapshot is taken on a rising edge with start high and busy low. Each
//   snapshot yields thirteen result beats, channels 0 to 12 in order, each
//   marked by result_strobe for one cycle; last is high on channel 12. The
//   receiver takes every beat and cannot hold them off.
//   cfg_write/cfg_data set ticks per second (zero stands for 60); write it
//   only while no snapshot is in flight.
//   The first beat of a snapshot reaches the ports after the input register
//   (loaded at the accepting edge), twelve divider stages with two quotient
//   bits per divider stage, three glyph stages and the serialiser; the other
//   beats of that snapshot follow it without gaps.
//   The serialiser emits one digit per cycle and so bounds the snapshot rate;
//   snapshots may be issued back to back and busy rises while the pipeline
//   waits on the serialiser.
//   Reset clears all pipeline valid bits and the serialiser, and sets ticks
//   per second to 60.
// ----------------------------------------------------------------------------
`include "scoreboard_digit_slot_decoder_core_assert.svh"

module scoreboard_digit_slot_decoder_core #(
  parameter int STEPS_PER_STAGE = sdsd_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 snapshot_ok,
  input  logic signed [sdsd_pkg::SCORE_W-1:0]  home_score,
  input  logic signed [sdsd_pkg::SCORE_W-1:0]  away_score,
  input  logic [sdsd_pkg::GAME_W-1:0]          game_clock_ticks,
  input  logic                                 game_clock_valid,
  input  logic [sdsd_pkg::SHOT_W-1:0]          shot_clock_ticks,
  input  logic                                 shot_clock_valid,
  input  logic signed [sdsd_pkg::QTR_W-1:0]    quarter_index,
  input  logic                                 cfg_write,
  input  logic [sdsd_pkg::TPS_W-1:0]           cfg_data,
  output logic                                 result_strobe,
  output logic [sdsd_pkg::CH_W-1:0]            channel,
  output logic [sdsd_pkg::GLYPH_W-1:0]         glyph_slot,
  output logic                                 last
);

  logic [sdsd_pkg::TPS_W-1:0]  tps;
  logic                        en;
  logic                        ser_ready;

  logic                        v0;
  sdsd_pkg::snap_t             snap0;
  logic [sdsd_pkg::GAME_W-1:0] game0;
  logic [sdsd_pkg::SHOT_W:0]   shot0;

  logic                        div_valid;
  logic [sdsd_pkg::GAME_W-1:0] div_total, div_shot;
  sdsd_pkg::snap_t             div_snap;

  logic                        glyph_valid;
  sdsd_pkg::glyph_vec_t        glyphs;

  // Ticks per second, stored with zero already mapped to the default.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= sdsd_pkg::DEFAULT_TPS;
    end else if (cfg_write) begin
      tps <= (cfg_data == '0) ? sdsd_pkg::DEFAULT_TPS : cfg_data;
    end
  end

  // The whole pipeline holds when a finished snapshot cannot enter the serialiser.
  assign en   = !glyph_valid || ser_ready;
  assign busy = !en;

  // Input register; the shot clock is biased for a rounding-up division.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      snap0.ok         <= snapshot_ok;
      snap0.home       <= home_score;
      snap0.away       <= away_score;
      snap0.game_valid <= game_clock_valid;
      snap0.shot_valid <= shot_clock_valid;
      snap0.quarter    <= quarter_index;
      game0            <= game_clock_ticks;
      shot0            <= {1'b0, shot_clock_ticks} + {1'b0, tps} - 1'b1;
    end
  end

  sdsd_div_pipe #(
    .STEPS_PER_STAGE (STEPS_PER_STAGE)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .in_game   (game0),
    .in_shot   (shot0),
    .in_snap   (snap0),
    .tps       (tps),
    .out_valid (div_valid),
    .out_total (div_total),
    .out_shot  (div_shot),
    .out_snap  (div_snap)
  );

  sdsd_glyph u_glyph (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (div_valid),
    .in_total   (div_total),
    .in_shot    (div_shot),
    .in_snap    (div_snap),
    .out_valid  (glyph_valid),
    .out_glyphs (glyphs)
  );

  sdsd_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (glyph_valid),
    .in_glyphs  (glyphs),
    .ready      (ser_ready),
    .strobe     (result_strobe),
    .channel    (channel),
    .glyph_slot (glyph_slot),
    .last       (last)
  );

  // The pipeline only stalls while the serialiser is mid-snapshot.
  `SDSD_ASSERT(a_busy_only_while_emitting, busy |-> (result_strobe && !last), "stall without beats in progress")
  // A stalled pipeline keeps its finished snapshot until the serialiser takes it.
  `SDSD_ASSERT(a_stall_keeps_glyphs, busy |=> (glyph_valid && $stable(glyphs)), "stalled snapshot lost")
  // Ticks per second never holds zero.
  `SDSD_ASSERT_NEVER(a_tps_nonzero, tps == '0, "zero divisor stored")

endmodule
